### sv/note_record_playback_sequencer_assert.svh
// Assertion macros for the note sequencer checker.
// Clock and reset are passed in; no other dependencies.
`ifndef NOTE_RECORD_PLAYBACK_SEQUENCER_ASSERT_SVH
`define NOTE_RECORD_PLAYBACK_SEQUENCER_ASSERT_SVH

// Checked only while out of reset.
`define NRPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define NRPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/nrps_pkg.sv
// Shared types and codes for the note record / playback sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nrps_pkg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CALC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_RECORD = 2'd1,
        MODE_PLAY   = 2'd2
    } mode_t;

    // One store entry: note code and octave multiplier (1, 2, 4 or 8).
    typedef struct packed {
        logic [3:0] note;
        logic [3:0] mult;
    } slot_t;

    localparam logic       OP_KEY  = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [4:0] NOTE_MAX   = 5'd11;
    localparam logic [4:0] KEY_OCTAVE = 5'd12;
    localparam logic [4:0] KEY_OFFSET = 5'd13;
    localparam logic [4:0] KEY_RECORD = 5'd14;
    localparam logic [4:0] KEY_PLAY   = 5'd15;
    localparam logic [4:0] KEY_NONE   = 5'd16;

    localparam logic [3:0] REST_NOTE  = 4'd12;
    localparam logic [3:0] CLEAR_MULT = 4'd1;

endpackage

`default_nettype wire

### sv/nrps_store.sv
// Note store: one write port, one registered read port.
// Uses nrps_pkg::slot_t.
`timescale 1ns / 1ps
`default_nettype none

module nrps_store #(
    parameter int SLOT_COUNT = 100,
    parameter int ADDR_W     = 7
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire nrps_pkg::slot_t     wr_data,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output nrps_pkg::slot_t          rd_data
);

    nrps_pkg::slot_t mem [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/nrps_tone.sv
// Tone timer reload from note, multiplier and semitone offset.
// Uses nrps_pkg codes. 500000/freq is tabled; the power-of-two multiplier is a shift.
`timescale 1ns / 1ps
`default_nettype none

module nrps_tone (
    input  wire logic              [3:0]  note,
    input  wire logic              [3:0]  mult,
    input  wire logic signed       [1:0]  offset,
    output logic                   [15:0] reload
);

    function automatic logic [10:0] div_base(input logic [3:0] n);
        logic [10:0] b;
        begin
            case (n)
                4'd0:    b = 11'd1908;
                4'd1:    b = 11'd1805;
                4'd2:    b = 11'd1700;
                4'd3:    b = 11'd1607;
                4'd4:    b = 11'd1515;
                4'd5:    b = 11'd1432;
                4'd6:    b = 11'd1351;
                4'd7:    b = 11'd1275;
                4'd8:    b = 11'd1204;
                4'd9:    b = 11'd1136;
                4'd10:   b = 11'd1072;
                4'd11:   b = 11'd1012;
                default: b = 11'd0;
            endcase
            return b;
        end
    endfunction

    logic [2:0]  mult_exp;
    logic [2:0]  eff_exp;
    logic [3:0]  eff_note;
    logic        silent;
    logic [10:0] quot;

    always_comb
    begin
        case (mult)
            4'd2:    mult_exp = 3'd1;
            4'd4:    mult_exp = 3'd2;
            4'd8:    mult_exp = 3'd3;
            default: mult_exp = 3'd0;
        endcase

        silent   = 1'b0;
        eff_exp  = mult_exp;
        eff_note = note;
        if (note > 4'(nrps_pkg::NOTE_MAX))
        begin
            silent = 1'b1;
        end
        else if (offset == 2'sd1 && note == 4'd11)
        begin
            // wrap up into the next octave
            eff_exp  = mult_exp + 3'd1;
            eff_note = 4'd0;
        end
        else if (offset == -2'sd1 && note == 4'd0)
        begin
            // wrap down; a multiplier of one halves to zero, which is silence
            silent   = (mult_exp == 3'd0);
            eff_exp  = mult_exp - 3'd1;
            eff_note = 4'd11;
        end
        else
        begin
            eff_note = note + {{2{offset[1]}}, offset};
        end

        quot   = div_base(eff_note) >> eff_exp;
        reload = silent ? 16'd0 : 16'(17'h10000 - {6'd0, quot});
    end

endmodule

`default_nettype wire

### sv/note_record_playback_sequencer.sv
// Note record / playback sequencer. An item is accepted in ST_IDLE and its result is
// registered in ST_CALC, which waits while the output is stalled; no new item is taken
// until then, as the note store has a registered read. Entering record mode sweeps the
// store to rests, one slot a cycle. After reset the same clearing pass runs with
// in_ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module note_record_playback_sequencer #(
    parameter int SLOT_COUNT = 100
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [4:0]  key_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      reload_value,
    output logic             tone_on,
    output logic [1:0]       play_mode,
    output logic [6:0]       slot_index
);

    localparam int PTR_W = $clog2(SLOT_COUNT);
    localparam int EXT_W = (PTR_W > 7) ? PTR_W : 7;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOT_COUNT - 1);

    nrps_pkg::state_t         state_reg, state_next;
    nrps_pkg::mode_t          mode_reg, mode_next;
    logic [1:0]               oct_exp_reg, oct_exp_next;
    logic signed [1:0]        offset_reg, offset_next;
    logic [4:0]               held_key_reg, held_key_next;
    logic [7:0]               tick_cnt_reg, tick_cnt_next;
    logic [PTR_W-1:0]         slot_ptr_reg, slot_ptr_next;
    logic [15:0]              reload_reg, reload_next;
    logic [7:0]               tps_reg;
    logic [PTR_W-1:0]         clr_addr_reg, clr_addr_next;
    logic                     clr_resp_reg, clr_resp_next;
    logic                     out_valid_reg, out_valid_next;
    logic [15:0]              out_reload_reg;
    logic                     out_tone_reg;
    logic [1:0]               out_mode_reg;
    logic [6:0]               out_slot_reg;
    logic                     out_load;

    logic                     st_wr_en;
    logic [PTR_W-1:0]         st_wr_addr;
    nrps_pkg::slot_t          st_wr_data;
    nrps_pkg::slot_t          st_rd_data;

    logic [3:0]               tone_note;
    logic [3:0]               tone_mult;
    logic [15:0]              tone_reload;

    logic [7:0]               tick_limit;
    logic [8:0]               tick_inc;
    logic                     held_is_note;
    logic [EXT_W-1:0]         ptr_ext;

    nrps_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .ADDR_W     (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (slot_ptr_next),
        .rd_data (st_rd_data)
    );

    // in playback the tone comes from the current slot, else from the held key
    assign tone_note = (mode_reg == nrps_pkg::MODE_PLAY) ? st_rd_data.note : held_key_reg[3:0];
    assign tone_mult = (mode_reg == nrps_pkg::MODE_PLAY) ? st_rd_data.mult
                                                         : 4'(4'd1 << oct_exp_reg);

    nrps_tone u_tone (
        .note   (tone_note),
        .mult   (tone_mult),
        .offset (offset_reg),
        .reload (tone_reload)
    );

    assign held_is_note = (held_key_reg <= nrps_pkg::NOTE_MAX);
    assign tick_limit   = (tps_reg == 8'd0) ? 8'd1 : tps_reg;
    assign tick_inc     = {1'b0, tick_cnt_reg} + 9'd1;
    assign ptr_ext      = EXT_W'(slot_ptr_reg);

    assign in_ready     = (state_reg == nrps_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign reload_value = out_reload_reg;
    assign tone_on      = out_tone_reg;
    assign play_mode    = out_mode_reg;
    assign slot_index   = out_slot_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        oct_exp_next  = oct_exp_reg;
        offset_next   = offset_reg;
        held_key_next = held_key_reg;
        tick_cnt_next = tick_cnt_reg;
        slot_ptr_next = slot_ptr_reg;
        reload_next   = reload_reg;
        clr_addr_next = clr_addr_reg;
        clr_resp_next = clr_resp_reg;
        st_wr_en      = 1'b0;
        st_wr_addr    = slot_ptr_reg;
        st_wr_data    = {held_key_reg[3:0], 4'(4'd1 << oct_exp_reg)};
        out_load      = 1'b0;

        unique case (state_reg)
            nrps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nrps_pkg::ST_CALC;
                    if (op == nrps_pkg::OP_KEY)
                    begin
                        held_key_next = key_code;
                        case (key_code)
                            nrps_pkg::KEY_OCTAVE:
                            begin
                                oct_exp_next = (oct_exp_reg < 2'd3) ? oct_exp_reg + 2'd1 : 2'd1;
                            end
                            nrps_pkg::KEY_OFFSET:
                            begin
                                offset_next = (offset_reg < 2'sd1) ? offset_reg + 2'sd1 : -2'sd1;
                            end
                            nrps_pkg::KEY_RECORD:
                            begin
                                slot_ptr_next = '0;
                                if (mode_reg != nrps_pkg::MODE_RECORD)
                                begin
                                    mode_next     = nrps_pkg::MODE_RECORD;
                                    state_next    = nrps_pkg::ST_CLEAR;
                                    clr_addr_next = '0;
                                    clr_resp_next = 1'b1;
                                end
                                else
                                begin
                                    mode_next = nrps_pkg::MODE_NORMAL;
                                end
                            end
                            nrps_pkg::KEY_PLAY:
                            begin
                                slot_ptr_next = '0;
                                reload_next   = 16'd0;
                                mode_next     = (mode_reg != nrps_pkg::MODE_PLAY)
                                                ? nrps_pkg::MODE_PLAY : nrps_pkg::MODE_NORMAL;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (tick_inc >= {1'b0, tick_limit})
                    begin
                        // slot boundary: in record mode record the held note, then advance
                        st_wr_en      = (mode_reg == nrps_pkg::MODE_RECORD) && held_is_note;
                        slot_ptr_next = (slot_ptr_reg == LAST_SLOT) ? '0
                                                                    : slot_ptr_reg + PTR_W'(1);
                        tick_cnt_next = 8'd0;
                    end
                    else
                    begin
                        tick_cnt_next = tick_inc[7:0];
                    end
                end
            end
            nrps_pkg::ST_CALC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = nrps_pkg::ST_IDLE;
                    if (mode_reg == nrps_pkg::MODE_PLAY || held_is_note)
                    begin
                        reload_next = tone_reload;
                    end
                end
            end
            nrps_pkg::ST_CLEAR:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = clr_addr_reg;
                st_wr_data = {nrps_pkg::REST_NOTE, nrps_pkg::CLEAR_MULT};
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next    = clr_resp_reg ? nrps_pkg::ST_CALC : nrps_pkg::ST_IDLE;
                    clr_resp_next = 1'b0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + PTR_W'(1);
                end
            end
            default:
            begin
                state_next = nrps_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nrps_pkg::ST_CLEAR;
            mode_reg      <= nrps_pkg::MODE_NORMAL;
            oct_exp_reg   <= 2'd1;
            offset_reg    <= 2'sd0;
            held_key_reg  <= nrps_pkg::KEY_NONE;
            tick_cnt_reg  <= 8'd0;
            slot_ptr_reg  <= '0;
            reload_reg    <= 16'd0;
            tps_reg       <= 8'd5;
            clr_addr_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            oct_exp_reg   <= oct_exp_next;
            offset_reg    <= offset_next;
            held_key_reg  <= held_key_next;
            tick_cnt_reg  <= tick_cnt_next;
            slot_ptr_reg  <= slot_ptr_next;
            reload_reg    <= reload_next;
            clr_addr_reg  <= clr_addr_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tps_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reload_reg <= reload_next;
            out_tone_reg   <= (mode_reg == nrps_pkg::MODE_PLAY) || held_is_note;
            out_mode_reg   <= mode_reg;
            out_slot_reg   <= ptr_ext[6:0];
        end
    end

endmodule

`default_nettype wire

### sv/nrps_checker.sv
// Port-level checks for the note sequencer, bound to the top level.
// Depends on note_record_playback_sequencer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "note_record_playback_sequencer_assert.svh"

module nrps_checker #(
    parameter int SLOT_COUNT = 100
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] reload_value,
    input wire logic        tone_on,
    input wire logic [1:0]  play_mode,
    input wire logic [6:0]  slot_index
);

    // a held result keeps its payload
    `NRPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(reload_value) && $stable(tone_on) && $stable(play_mode) && $stable(slot_index), "result changed while stalled")

    // one item at a time: busy in the cycle after an accept
    `NRPS_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "item accepted back to back")

    `NRPS_ASSERT(a_play_tone, clk, rst_n, out_valid && play_mode == 2'd2 |-> tone_on, "playback result without tone")

    `NRPS_ASSERT(a_slot_range, clk, rst_n, out_valid && SLOT_COUNT <= 128 |-> 32'(slot_index) < SLOT_COUNT, "slot index past store end")

    `NRPS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !out_valid && !in_ready, "handshake active in reset")

endmodule

bind note_record_playback_sequencer nrps_checker #(.SLOT_COUNT(SLOT_COUNT)) u_nrps_checker (.*);

`default_nettype wire
